// File: sv/pctc_pkg.sv
// Package for the prefix code table codec: request and status codes,
// stream field layout and the sequencer state type.
// No dependencies; the top level, the checker and the bench import it.
package pctc_pkg;

	// Request kinds carried on s_tuser
	localparam int REQ_W = 2;
	localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ENCODE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DECODE = 2'd2;

	// Result kinds carried on m_tuser
	localparam int STAT_W = 2;
	localparam logic [STAT_W-1:0] STAT_CODE     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SYMBOL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNKNOWN  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd3;

	// Fixed field widths
	localparam int IDXF_W = 8;
	localparam int SYM_W  = 8;
	localparam int LENF_W = 6;
	localparam int CODE_W = 32;
	localparam int CNT_W  = 9;

	// s_tdata layout, lowest bit first
	localparam int IN_IDX_LSB  = 0;
	localparam int IN_SYM_LSB  = IN_IDX_LSB + IDXF_W;
	localparam int IN_LEN_LSB  = IN_SYM_LSB + SYM_W;
	localparam int IN_CODE_LSB = IN_LEN_LSB + LENF_W;
	localparam int IN_BIT_LSB  = IN_CODE_LSB + CODE_W;
	localparam int S_TDATA_W   = 56;

	// m_tdata layout, lowest bit first
	localparam int OUT_SYM_LSB  = 0;
	localparam int OUT_LEN_LSB  = OUT_SYM_LSB + SYM_W;
	localparam int OUT_CODE_LSB = OUT_LEN_LSB + LENF_W;
	localparam int M_TDATA_W    = 48;

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_ENC_RD   = 5'b00010,
		ST_ENC_DATA = 5'b00100,
		ST_SEARCH   = 5'b01000,
		ST_HOLD     = 5'b10000
	} state_t;

endpackage

// File: sv/pctc_entry_ram.sv
// Code table memory: one write port, one registered read port.
// Depends on nothing; instantiated by the codec top level.
module pctc_entry_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 46
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/prefix_code_table_codec_core.sv
// Prefix code table codec top level: request decode, symbol map, search
// sequencer and result register. Uses pctc_pkg and pctc_entry_ram.
//
// Channel   Dir  Handshake             Payload
// s_        in   s_tvalid / s_tready   s_tuser = req_type, s_tdata = request fields
// m_        out  m_tvalid / m_tready   m_tuser = status, m_tdata = result fields
// cfg_      in   cfg_valid / cfg_ready cfg_data = symbol_count
//
// Steps: a load writes the table and leaves the block ready; an encode runs
// map read, table read, result and hand-off; a decode bit reads up to
// min(symbol_count, TABLE_DEPTH) entries, hands off a result on a match or an
// overflow and else ends without one; the single table read port feeds
// one entry per cycle to the one compare unit, and the first (highest)
// match cuts the walk short. Reset clears the control state, the accumulator,
// the symbol count and the symbol map valid bits at once; no clearing pass. A
// finished result waits in the output register while the next request is taken;
// the sequencer only stalls when a second result is ready before the first leaves.
module prefix_code_table_codec_core
	import pctc_pkg::*;
#(
	parameter int MAX_CODE_LEN = 32,
	parameter int TABLE_DEPTH  = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// entry_index[7:0], symbol[15:8], code_length[21:16], code_bits[53:22],
	// bit_in[54], zero fill[55]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// req_type[1:0]
	input  logic [REQ_W-1:0]     s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_symbol[7:0], out_length[13:8], out_code[45:14], zero fill[47:46]
	output logic [M_TDATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [STAT_W-1:0]    m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CNT_W-1:0]     cfg_data
);

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
	localparam int LEFT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int CODE_XW = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int LEN_XW  = (LEN_W > LENF_W) ? LEN_W : LENF_W;
	localparam int ENT_W   = SYM_W + LEN_W + MAX_CODE_LEN;
	localparam int MAP_D   = 1 << SYM_W;

	// Request fields
	logic [IDXF_W-1:0] in_idx;
	logic [SYM_W-1:0]  in_sym;
	logic [LENF_W-1:0] in_len;
	logic [CODE_W-1:0] in_code;
	logic              in_bit;

	assign in_idx  = s_tdata[IN_IDX_LSB +: IDXF_W];
	assign in_sym  = s_tdata[IN_SYM_LSB +: SYM_W];
	assign in_len  = s_tdata[IN_LEN_LSB +: LENF_W];
	assign in_code = s_tdata[IN_CODE_LSB +: CODE_W];
	assign in_bit  = s_tdata[IN_BIT_LSB];

	state_t state_q;

	logic                    s_fire;
	logic                    load_fire;
	logic [LEN_W-1:0]        ld_len;
	logic [CODE_XW-1:0]      ld_code_x;
	logic [ENT_W-1:0]        wr_data;

	// Symbol map: valid bits in flops, entry pointers in a memory
	logic [MAP_D-1:0]        map_valid_q;
	logic [IDX_W-1:0]        map_mem_q [MAP_D];
	logic [IDX_W-1:0]        map_ent_q;
	logic                    map_hit_q;
	logic [SYM_W-1:0]        sym_q;

	// Decode accumulator and search control
	logic [MAX_CODE_LEN-1:0] acc_q;
	logic [LEN_W-1:0]        acc_len_q;
	logic [LEFT_W-1:0]       left_q;
	logic [LEFT_W-1:0]       n_search;
	logic [CNT_W-1:0]        symbol_count_q;
	logic                    rd_pend_s1;

	// Table read port
	logic                    rd_en;
	logic                    issue;
	logic [IDX_W-1:0]        rd_addr;
	logic [ENT_W-1:0]        rd_data;
	logic [SYM_W-1:0]        rd_sym;
	logic [LEN_W-1:0]        rd_len;
	logic [MAX_CODE_LEN-1:0] rd_code;
	logic                    hit;

	// Result staging and output register
	logic [STAT_W-1:0]       res_stat_q;
	logic [SYM_W-1:0]        res_sym_q;
	logic [LENF_W-1:0]       res_len_q;
	logic [CODE_W-1:0]       res_code_q;
	logic                    m_valid_q;
	logic [STAT_W-1:0]       m_stat_q;
	logic [SYM_W-1:0]        m_sym_q;
	logic [LENF_W-1:0]       m_len_q;
	logic [CODE_W-1:0]       m_code_q;

	logic [LEN_XW-1:0]       acc_len_x;
	logic [CODE_XW-1:0]      acc_x;
	logic [LEN_XW-1:0]       rd_len_x;
	logic [CODE_XW-1:0]      rd_code_x;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_fire    = s_tvalid && s_tready;

	// Drop loads aimed beyond the table
	assign load_fire = s_fire && (s_tuser == REQ_LOAD) &&
		({1'b0, in_idx} < (IDXF_W + 1)'(TABLE_DEPTH));

	// Saturate the length, then mask the code to it
	assign ld_len    = (int'(in_len) > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : LEN_W'(in_len);
	assign ld_code_x = CODE_XW'(in_code) & ~({CODE_XW{1'b1}} << ld_len);
	assign wr_data   = {in_sym, ld_len, ld_code_x[MAX_CODE_LEN-1:0]};

	assign n_search = (int'(symbol_count_q) > TABLE_DEPTH) ?
		LEFT_W'(TABLE_DEPTH) : LEFT_W'(symbol_count_q);

	assign {rd_sym, rd_len, rd_code} = rd_data;

	// Search walks down from the top entry; the first hit is the highest index
	assign hit   = (state_q == ST_SEARCH) && rd_pend_s1 &&
		(rd_len == acc_len_q) && (rd_code == acc_q);
	assign issue = (state_q == ST_SEARCH) && (left_q != '0) && !hit;
	assign rd_en = issue || (state_q == ST_ENC_RD);

	always_comb begin
		if (state_q == ST_ENC_RD) begin
			rd_addr = map_ent_q;
		end else begin
			rd_addr = IDX_W'(left_q - LEFT_W'(1));
		end
	end

	assign acc_len_x = LEN_XW'(acc_len_q);
	assign acc_x     = CODE_XW'(acc_q);
	assign rd_len_x  = LEN_XW'(rd_len);
	assign rd_code_x = CODE_XW'(rd_code);

	pctc_entry_ram #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (IDX_W),
		.DATA_W (ENT_W)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (load_fire),
		.wr_addr (IDX_W'(in_idx)),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Map pointer memory: write on load, read on encode request
	always_ff @(posedge clk) begin
		if (load_fire) begin
			map_mem_q[in_sym] <= IDX_W'(in_idx);
		end
		if (s_fire && (s_tuser == REQ_ENCODE)) begin
			map_ent_q <= map_mem_q[in_sym];
		end
	end

	// Result payload staging: no reset needed
	always_ff @(posedge clk) begin
		if (s_fire && (s_tuser == REQ_ENCODE)) begin
			sym_q <= in_sym;
		end
		unique case (state_q)
			ST_ENC_DATA: begin
				res_sym_q <= sym_q;
				if (map_hit_q) begin
					res_stat_q <= STAT_CODE;
					res_len_q  <= rd_len_x[LENF_W-1:0];
					res_code_q <= rd_code_x[CODE_W-1:0];
				end else begin
					res_stat_q <= STAT_UNKNOWN;
					res_len_q  <= '0;
					res_code_q <= '0;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					res_stat_q <= STAT_SYMBOL;
					res_sym_q  <= rd_sym;
				end else begin
					res_stat_q <= STAT_OVERFLOW;
					res_sym_q  <= '0;
				end
				res_len_q  <= acc_len_x[LENF_W-1:0];
				res_code_q <= acc_x[CODE_W-1:0];
			end
			default: begin
			end
		endcase
		if ((state_q == ST_HOLD) && (!m_valid_q || m_tready)) begin
			m_stat_q <= res_stat_q;
			m_sym_q  <= res_sym_q;
			m_len_q  <= res_len_q;
			m_code_q <= res_code_q;
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			map_valid_q    <= '0;
			map_hit_q      <= 1'b0;
			acc_q          <= '0;
			acc_len_q      <= '0;
			left_q         <= '0;
			symbol_count_q <= '0;
			rd_pend_s1     <= 1'b0;
			m_valid_q      <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				symbol_count_q <= cfg_data;
			end
			if (load_fire) begin
				map_valid_q[in_sym] <= 1'b1;
			end
			// advance the staged result into a free output register
			if ((state_q == ST_HOLD) && (!m_valid_q || m_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						case (s_tuser)
							REQ_ENCODE: begin
								map_hit_q <= map_valid_q[in_sym];
								state_q   <= ST_ENC_RD;
							end
							REQ_DECODE: begin
								// shift the new bit in, then search the table
								acc_q     <= (acc_q << 1) | MAX_CODE_LEN'(in_bit);
								acc_len_q <= acc_len_q + LEN_W'(1);
								left_q    <= n_search;
								state_q   <= ST_SEARCH;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ENC_RD: begin
					state_q <= ST_ENC_DATA;
				end
				ST_ENC_DATA: begin
					state_q <= ST_HOLD;
				end
				ST_SEARCH: begin
					if (hit) begin
						acc_q     <= '0;
						acc_len_q <= '0;
						state_q   <= ST_HOLD;
					end else if ((left_q == '0) && !rd_pend_s1) begin
						if (acc_len_q == LEN_W'(MAX_CODE_LEN)) begin
							acc_q     <= '0;
							acc_len_q <= '0;
							state_q   <= ST_HOLD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else if (issue) begin
						left_q <= left_q - LEFT_W'(1);
					end
				end
				ST_HOLD: begin
					// hold until the output register is free
					if (!m_valid_q || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_stat_q;
	assign m_tdata  = {{(M_TDATA_W - OUT_CODE_LSB - CODE_W){1'b0}}, m_code_q, m_len_q, m_sym_q};

endmodule

// File: sv/pctc_checker.sv
// Port-level checker for the prefix code table codec, bound to the top level.
// Depends on pctc_pkg and prefix_code_table_codec_core.
module pctc_checker
	import pctc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [REQ_W-1:0]     s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [STAT_W-1:0]    m_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result dropped or changed while stalled");

	// Encode and decode requests take the sequencer out of idle, so it is busy after them
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_ENCODE || s_tuser == REQ_DECODE)
		|=> !s_tready)
		else $error("request taken while sequencer busy");

	// Unknown symbol carries no length and no code
	a_unknown_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_UNKNOWN) |-> m_tdata[M_TDATA_W-1:OUT_LEN_LSB] == '0)
		else $error("unknown symbol result with length or code");

	// Overflow carries a zero symbol and zero fill bits
	a_overflow_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_OVERFLOW)
		|-> m_tdata[OUT_SYM_LSB +: SYM_W] == '0 && m_tdata[M_TDATA_W-1:M_TDATA_W-2] == '0)
		else $error("malformed overflow result");

endmodule

bind prefix_code_table_codec_core pctc_checker u_pctc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: verif/prefix_code_table_codec_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for prefix_code_table_codec_core: load, encode and decode
// requests under random flow control, each result checked against a behavioural
// model of the code table held here. Needs pctc_pkg and the core RTL.
module prefix_code_table_codec_core_tb
	import pctc_pkg::*;
();

	localparam int CLK_PERIOD = 12;
	localparam int MAX_LEN    = 32;
	localparam int DEPTH      = 256;
	// longest search that ends without a result (full table plus overhead), with margin
	localparam int SETTLE     = 300;
	localparam int LIMIT      = 3_000_000;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [REQ_W-1:0]  kind;
		logic [IDXF_W-1:0] slot;
		logic [SYM_W-1:0]  sym;
		logic [LENF_W-1:0] len;
		logic [CODE_W-1:0] code;
		logic              bit_in;
	} codec_req_t;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [SYM_W-1:0]  sym;
		logic [LENF_W-1:0] len;
		logic [CODE_W-1:0] code;
	} codec_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [REQ_W-1:0]     s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]    m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CNT_W-1:0]     cfg_data;

	prefix_code_table_codec_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Code table model
	logic [SYM_W-1:0]  tbl_sym   [DEPTH] = '{default: '0};
	logic [LENF_W-1:0] tbl_len   [DEPTH] = '{default: '0};
	logic [CODE_W-1:0] tbl_code  [DEPTH] = '{default: '0};
	bit                map_valid [256]   = '{default: 1'b0};
	logic [IDXF_W-1:0] map_slot  [256]   = '{default: '0};
	logic [CODE_W-1:0] acc_bits  = '0;
	int                acc_len   = 0;
	int unsigned       count_cfg = 0;
	codec_res_t        expected_results[$];

	int          requests_sent  = 0;
	int          mismatch_count = 0;
	int          status_seen[4] = '{default: 0};
	int          cycle_count    = 0;
	int          sink_hold      = 0;
	bit          src_stalls     = 1'b1;
	bit          sink_stalls    = 1'b1;
	codec_res_t  got;
	codec_res_t  want;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic codec_req_t make_request(input logic [REQ_W-1:0] kind,
			input logic [IDXF_W-1:0] slot, input logic [SYM_W-1:0] sym,
			input logic [LENF_W-1:0] len, input logic [CODE_W-1:0] code,
			input logic bit_in);
		codec_req_t r;
		r.kind   = kind;
		r.slot   = slot;
		r.sym    = sym;
		r.len    = len;
		r.code   = code;
		r.bit_in = bit_in;
		return r;
	endfunction

	// Mostly short codes so that decodes hit often; a few long and overlong ones
	function automatic codec_req_t random_load(input logic [IDXF_W-1:0] slot);
		int pick;
		int len;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			len = 0;
		else if (pick < 14)
			len = $urandom_range(1, 6);
		else if (pick < 18)
			len = $urandom_range(7, MAX_LEN);
		else
			len = $urandom_range(MAX_LEN + 1, 63);
		return make_request(REQ_LOAD, slot, SYM_W'($urandom_range(0, 255)), LENF_W'(len),
			$urandom, 1'b0);
	endfunction

	// Advance the model by one accepted request and queue any result it causes
	function automatic void predict_codec(input codec_req_t r);
		int         n;
		int         l;
		int         e;
		int         hit;
		codec_res_t res;
		case (r.kind)
			REQ_LOAD: begin
				l = (r.len > MAX_LEN) ? MAX_LEN : r.len;
				tbl_sym[r.slot]  = r.sym;
				tbl_len[r.slot]  = LENF_W'(l);
				tbl_code[r.slot] = (l == 0) ? '0 : r.code & ({CODE_W{1'b1}} >> (CODE_W - l));
				map_valid[r.sym] = 1'b1;
				map_slot[r.sym]  = r.slot;
			end
			REQ_ENCODE: begin
				res.sym = r.sym;
				if (map_valid[r.sym]) begin
					res.status = STAT_CODE;
					res.len    = tbl_len[map_slot[r.sym]];
					res.code   = tbl_code[map_slot[r.sym]];
				end else begin
					res.status = STAT_UNKNOWN;
					res.len    = '0;
					res.code   = '0;
				end
				expected_results.push_back(res);
			end
			REQ_DECODE: begin
				n        = (count_cfg > DEPTH) ? DEPTH : count_cfg;
				acc_bits = {acc_bits[CODE_W-2:0], r.bit_in};
				acc_len++;
				// search downwards: the highest matching slot wins
				hit = -1;
				for (e = n - 1; e >= 0 && hit < 0; e--)
					if (tbl_len[e] == acc_len && tbl_code[e] == acc_bits)
						hit = e;
				if (hit >= 0 || acc_len >= MAX_LEN) begin
					res.status = (hit >= 0) ? STAT_SYMBOL : STAT_OVERFLOW;
					res.sym    = (hit >= 0) ? tbl_sym[hit] : '0;
					res.len    = LENF_W'(acc_len);
					res.code   = acc_bits;
					expected_results.push_back(res);
					acc_bits = '0;
					acc_len  = 0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Offer one request, optionally after an idle gap, and hold it until taken
	task automatic send_request(input codec_req_t r);
		int gap;
		gap = (src_stalls && $urandom_range(0, 1)) ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.kind;
		// zero fill, bit_in, code_bits, code_length, symbol, entry_index
		s_tdata  <= {1'b0, r.bit_in, r.code, r.len, r.sym, r.slot};
		do @(posedge clk); while (!s_tready);
		predict_codec(r);
		if (r.kind != REQ_UNUSED)
			requests_sent++;
	endtask

	task automatic send_code_bits(input logic [CODE_W-1:0] code, input int len);
		int i;
		for (i = len - 1; i >= 0; i--)
			send_request(make_request(REQ_DECODE, '0, '0, '0, '0, code[i]));
	endtask

	task automatic send_noise_bits();
		repeat ($urandom_range(1, 4))
			send_request(make_request(REQ_DECODE, IDXF_W'($urandom), SYM_W'($urandom),
				LENF_W'($urandom), $urandom, 1'($urandom_range(0, 1))));
	endtask

	// Drop valid and hold off until every queued result has been taken
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Write the count only once the block is idle; a silent decode may still be searching
	task automatic set_symbol_count(input logic [CNT_W-1:0] value);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_cfg = value;
	endtask

	task automatic test_directed();
		// nothing mapped yet: unknown symbol
		send_request(make_request(REQ_ENCODE, 8'd0, 8'h00, '0, '0, 1'b0));
		// unused request kind with every field bit set: no result
		send_request(make_request(REQ_UNUSED, 8'hFF, 8'hFF, 6'h3F, 32'hFFFF_FFFF, 1'b1));
		// code masked to three bits
		send_request(make_request(REQ_LOAD, 8'd0, 8'h41, 6'd3, 32'hFFFF_FFFF, 1'b0));
		// zero length: never decodes
		send_request(make_request(REQ_LOAD, 8'd1, 8'h42, 6'd0, 32'h0000_0000, 1'b0));
		// overlong length saturates
		send_request(make_request(REQ_LOAD, 8'd2, 8'hFF, 6'd40, 32'hA5A5_A5A5, 1'b0));
		// same code as slot 0: the higher slot must win
		send_request(make_request(REQ_LOAD, 8'd3, 8'h43, 6'd3, 32'h0000_0007, 1'b0));
		send_request(make_request(REQ_LOAD, 8'd255, 8'h44, 6'd63, 32'hFFFF_FFFF, 1'b0));
		send_request(make_request(REQ_ENCODE, '0, 8'h41, '0, '0, 1'b0));
		send_request(make_request(REQ_ENCODE, '0, 8'hFF, '0, '0, 1'b0));
		send_request(make_request(REQ_ENCODE, '0, 8'h42, '0, '0, 1'b0));
		send_request(make_request(REQ_ENCODE, '0, 8'h44, '0, '0, 1'b0));
		// remap a symbol to a new slot
		send_request(make_request(REQ_LOAD, 8'd4, 8'h41, 6'd2, 32'h0000_0001, 1'b0));
		send_request(make_request(REQ_ENCODE, '0, 8'h41, '0, '0, 1'b0));
		set_symbol_count(9'd5);
		send_code_bits(32'h7, 3);
		send_code_bits(32'h1, 2);
	endtask

	task automatic test_max_length();
		// full-length code, then thirty-two zeros that match nothing
		send_code_bits(32'hA5A5_A5A5, MAX_LEN);
		send_code_bits(32'h0000_0000, MAX_LEN);
	endtask

	task automatic test_count_zero();
		int pick;
		set_symbol_count(9'd0);
		repeat (160) begin
			pick = $urandom_range(0, 19);
			if (pick < 17)
				send_noise_bits();
			else if (pick < 19)
				send_request(make_request(REQ_ENCODE, IDXF_W'($urandom), SYM_W'($urandom),
					LENF_W'($urandom), $urandom, 1'($urandom_range(0, 1))));
			else
				send_request(random_load(IDXF_W'($urandom_range(0, 255))));
		end
	endtask

	// Write every slot so that any count may be searched from here on
	task automatic test_fill_table();
		int slot;
		for (slot = 0; slot < DEPTH; slot++)
			send_request(random_load(IDXF_W'(slot)));
	endtask

	task automatic test_random_phase(input logic [CNT_W-1:0] count, input int budget);
		int start;
		int n;
		int pick;
		int e;
		int k;
		set_symbol_count(count);
		n     = (count > DEPTH) ? DEPTH : count;
		start = requests_sent;
		while (requests_sent - start < budget) begin
			if ($urandom_range(0, 63) == 0) begin
				src_stalls  = ($urandom_range(0, 2) != 0);
				sink_stalls = ($urandom_range(0, 2) != 0);
			end
			if ($urandom_range(0, 199) == 0)
				wait_drained();
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				send_request(random_load(IDXF_W'($urandom_range(0, 255))));
			end else if (pick < 35) begin
				k = $urandom_range(0, 1) ? tbl_sym[$urandom_range(0, DEPTH - 1)]
					: $urandom_range(0, 255);
				send_request(make_request(REQ_ENCODE, IDXF_W'($urandom), SYM_W'(k),
					LENF_W'($urandom), $urandom, 1'($urandom_range(0, 1))));
			end else if (pick < 90) begin
				// well-formed: replay the code of a searched slot
				e = -1;
				repeat (4) begin
					k = $urandom_range(0, (n > 0) ? n - 1 : 0);
					if (n > 0 && e < 0 && tbl_len[k] != 0 && tbl_len[k] <= 12)
						e = k;
				end
				if (e >= 0)
					send_code_bits(tbl_code[e], tbl_len[e]);
				else
					send_noise_bits();
			end else if (pick < 98) begin
				send_noise_bits();
			end else begin
				send_request(make_request(REQ_UNUSED, IDXF_W'($urandom), SYM_W'($urandom),
					LENF_W'($urandom), $urandom, 1'($urandom_range(0, 1))));
			end
		end
	endtask

	// Result sink: random back-pressure
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			m_tready  <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			m_tready <= 1'b1;
			if (sink_stalls && $urandom_range(0, 4) == 0)
				sink_hold <= idle_len();
		end
	end

	// Compare each accepted result with the oldest one queued
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got.status = m_tuser;
			got.sym    = m_tdata[OUT_SYM_LSB +: SYM_W];
			got.len    = m_tdata[OUT_LEN_LSB +: LENF_W];
			got.code   = m_tdata[OUT_CODE_LSB +: CODE_W];
			if (expected_results.size() == 0) begin
				$error("result with none expected: status %0d symbol %0h", got.status, got.sym);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				status_seen[want.status]++;
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.sym !== want.sym) begin
					$error("out_symbol: expected %0h, got %0h", want.sym, got.sym);
					mismatch_count++;
				end
				if (got.len !== want.len) begin
					$error("out_length: expected %0d, got %0d", want.len, got.len);
					mismatch_count++;
				end
				if (got.code !== want.code) begin
					$error("out_code: expected %0h, got %0h", want.code, got.code);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("prefix_code_table_codec_core_tb: errors");
			$finish;
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_LOAD;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_max_length();
		test_count_zero();
		test_fill_table();
		test_random_phase(9'd16, 340);
		test_random_phase(9'd64, 320);
		test_random_phase(9'd256, 240);
		test_random_phase(9'd511, 120);
		test_random_phase(9'd1, 110);

		wait_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Ran %0d requests with symbol counts 0, 1, 5, 16, 64, 256 and 511.",
			requests_sent);
		$display("Checked %0d code words, %0d unknown, %0d decoded, %0d overflows.",
			status_seen[STAT_CODE], status_seen[STAT_UNKNOWN], status_seen[STAT_SYMBOL],
			status_seen[STAT_OVERFLOW]);
		if (mismatch_count == 0)
			$display("prefix_code_table_codec_core_tb: clean");
		else
			$display("prefix_code_table_codec_core_tb: errors");
		$finish;
	end

endmodule
